### rtl/assert_macros.svh
// Assertion macros for the RTL of the concentric disk map.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CDM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CDM_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define CDM_ASSERT(label, clk, rst, prop)
`define CDM_ASSERT_NR(label, clk, prop)
`endif

`endif

### rtl/cdm_pkg.sv
// Shared types and constants of the concentric disk map.
// No dependencies.
`default_nettype none

package cdm_pkg;

   typedef enum logic [1:0] {
      REG_EAST  = 2'd0,
      REG_NORTH = 2'd1,
      REG_WEST  = 2'd2,
      REG_SOUTH = 2'd3
   } region_type;

   // Request travelling down the divider chain; den is also the radius.
   typedef struct packed {
      logic [16:0] rem;
      logic [16:0] quo;
      logic [16:0] den;
      region_type  region;
      logic        add;
   } div_data_type;

   localparam logic signed [31:0] SIN_K0 = 32'sd843314857;
   localparam logic signed [31:0] SIN_K1 = -32'sd86699834;
   localparam logic signed [31:0] SIN_K2 = 32'sd2674041;
   localparam logic signed [31:0] SIN_K3 = -32'sd39273;
   localparam logic signed [31:0] COS_K0 = -32'sd331168970;
   localparam logic signed [31:0] COS_K1 = 32'sd17023474;
   localparam logic signed [31:0] COS_K2 = -32'sd350031;
   localparam logic signed [31:0] COS_K3 = 32'sd3856;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

endpackage

`default_nettype wire

### rtl/concentric_disk_map_core.sv
// Concentric disk map: each request passes through a pipeline to its result
// (1 input stage, 17 divider cells, 8 trig stages); one request per cycle
// sustained while the result side accepts, set by the one-bit-per-cell divider chain and the trig pipeline.
// Synchronous active-high reset clears all valid bits; payload is not reset.
`default_nettype none
`include "assert_macros.svh"

module concentric_disk_map_core
   import cdm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [15:0]        req_u_coord,
   input  wire logic [15:0]        req_v_coord,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_disk_x,
   output logic signed [15:0]      rsp_disk_y
);

   localparam int Cells = 17;

   logic signed [17:0] a, b, na, nb;
   logic [16:0]        mag_a, mag_b;
   div_data_type       data_in, data_ff;
   logic               valid_ff;

   logic               cell_valid [Cells + 1];
   logic               cell_ready [Cells + 1];
   div_data_type       cell_data  [Cells + 1];

   always_comb begin
      a     = $signed({1'b0, req_u_coord, 1'b0}) - 18'sd65536;
      b     = $signed({1'b0, req_v_coord, 1'b0}) - 18'sd65536;
      na    = -a;
      nb    = -b;
      mag_a = a[17] ? na[16:0] : a[16:0];
      mag_b = b[17] ? nb[16:0] : b[16:0];
      data_in.quo = '0;
      if (a > nb) begin
         if (a > b) begin
            data_in.region = REG_EAST;
            data_in.rem    = mag_b;
            data_in.den    = a[16:0];
            data_in.add    = !b[17];
         end else begin
            data_in.region = REG_NORTH;
            data_in.rem    = mag_a;
            data_in.den    = b[16:0];
            data_in.add    = a[17];
         end
      end else if (a < b) begin
         data_in.region = REG_WEST;
         data_in.rem    = mag_b;
         data_in.den    = mag_a;
         data_in.add    = b[17];
      end else begin
         data_in.region = REG_SOUTH;
         data_in.rem    = mag_a;
         data_in.den    = mag_b;
         data_in.add    = !a[17];
      end
   end

   assign req_ready = !valid_ff || cell_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         data_ff <= data_in;
      end
   end

   assign cell_valid[0] = valid_ff;
   assign cell_data[0]  = data_ff;

   for (genvar i = 0; i < Cells; i++) begin : g_div
      cdm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_ready  (cell_ready[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i + 1]),
         .out_ready (cell_ready[i + 1]),
         .out_data  (cell_data[i + 1])
      );
   end

   cdm_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cell_valid[Cells]),
      .in_ready  (cell_ready[Cells]),
      .in_data   (cell_data[Cells]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_x     (rsp_disk_x),
      .out_y     (rsp_disk_y)
   );

   // an empty or draining output stage never blocks the input side
   `CDM_ASSERT(a_ready_when_out_free, clock, reset, (!rsp_valid || rsp_ready) |-> req_ready)
   `CDM_ASSERT_NR(a_empty_after_reset, clock, reset |=> !rsp_valid)

endmodule

`default_nettype wire

### rtl/cdm_div_cell.sv
// One restoring division step with a pipeline register and handshake.
// Depends on cdm_pkg.
`default_nettype none

module cdm_div_cell
   import cdm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire div_data_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output div_data_type      out_data
);

   logic         valid_ff, valid_in;
   div_data_type data_ff, data_in;
   logic [18:0]  diff;
   logic         ge;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      diff    = {1'b0, in_data.rem, 1'b0} - {2'b0, in_data.den};
      ge      = !diff[18];
      data_in = in_data;
      data_in.rem = ge ? diff[16:0] : {in_data.rem[15:0], 1'b0};
      data_in.quo = {in_data.quo[15:0], ge};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### rtl/cdm_trig.sv
// Phase, sine/cosine polynomial, rotation and output scaling pipeline.
// Depends on cdm_pkg.
`default_nettype none

module cdm_trig
   import cdm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire div_data_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic signed [15:0] out_x,
   output logic signed [15:0] out_y
);

   localparam int Stages = 8;

   function automatic logic signed [31:0] qmul30(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
      logic        neg;
      logic [31:0] ux, uy;
      logic [63:0] prod;
      logic [63:0] rnd;
      neg  = x[31] ^ y[31];
      ux   = x[31] ? 32'(-x) : 32'(x);
      uy   = y[31] ? 32'(-y) : 32'(y);
      prod = {32'b0, ux} * {32'b0, uy};
      rnd  = (prod + (64'd1 << 29)) >> 30;
      return neg ? -$signed(rnd[31:0]) : $signed(rnd[31:0]);
   endfunction

   function automatic logic signed [15:0] scale(input logic [16:0] r,
                                                input logic signed [31:0] t);
      logic        neg;
      logic [31:0] ut;
      logic [48:0] prod;
      logic [48:0] rnd;
      logic [17:0] m;
      neg  = t[31];
      ut   = neg ? 32'(-t) : 32'(t);
      prod = 49'(r) * 49'(ut);
      rnd  = prod + (49'd1 << 30);
      m    = rnd[48:31];
      if (neg) begin
         return (m > 18'd32768) ? -16'sd32768 : -$signed(m[15:0]);
      end
      return (m > 18'd32767) ? 16'sd32767 : $signed(m[15:0]);
   endfunction

   function automatic logic [33:0] arg2_in_sq(input logic [16:0] v);
      return 34'(v) * 34'(v);
   endfunction

   logic [Stages:1] valid_ff, en;

   logic [16:0] arg1_ff, arg2_ff, arg3_ff, arg4_ff, arg5_ff;
   logic [2:0]  oct1_ff, oct2_ff, oct3_ff, oct4_ff, oct5_ff, oct6_ff;
   logic [16:0] r1_ff, r2_ff, r3_ff, r4_ff, r5_ff, r6_ff, r7_ff;
   logic signed [31:0] z2_ff, z3_ff, z4_ff, z5_ff;
   logic signed [31:0] ps3_ff, ps4_ff, ps5_ff, pc3_ff, pc4_ff, pc5_ff;
   logic signed [31:0] c6_ff, s6_ff, cr7_ff, sr7_ff;
   logic signed [15:0] x8_ff, y8_ff;

   logic [17:0] qsum;
   logic [16:0] m_in, arg1_in;
   logic [18:0] base, phase;
   logic [33:0] sq;
   logic signed [31:0] z2_in, f_q30, s_raw, c_raw, cr7_in, sr7_in;

   always_comb begin
      en[Stages] = !valid_ff[Stages] || out_ready;
      for (int i = Stages - 1; i >= 1; i--) begin
         en[i] = !valid_ff[i] || en[i + 1];
      end
   end
   assign in_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= in_valid;
         end
         for (int i = 2; i <= Stages; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i - 1];
            end
         end
      end
   end

   // phase = region base +/- rounded ratio, modulo eight octants
   always_comb begin
      qsum    = {1'b0, in_data.quo} + 18'd1;
      m_in    = qsum[17:1];
      base    = {in_data.region, 17'd0};
      phase   = in_data.add ? base + {2'b0, m_in} : base - {2'b0, m_in};
      arg1_in = phase[16] ? 17'h10000 - {1'b0, phase[15:0]} : {1'b0, phase[15:0]};
   end

   always_comb begin
      sq    = 34'(arg2_in_sq(arg1_ff));
      z2_in = $signed({1'b0, 31'((sq + 34'd2) >> 2)});
   end

   always_comb begin
      f_q30 = $signed({1'b0, arg5_ff, 14'd0});
      s_raw = qmul30(f_q30, ps5_ff);
      c_raw = qmul30(z5_ff, pc5_ff) + ONE_Q30;
   end

   // quarter-turn rotation
   always_comb begin
      case (oct6_ff[2:1])
         2'd0:    begin cr7_in = c6_ff;  sr7_in = s6_ff;  end
         2'd1:    begin cr7_in = -s6_ff; sr7_in = c6_ff;  end
         2'd2:    begin cr7_in = -c6_ff; sr7_in = -s6_ff; end
         default: begin cr7_in = s6_ff;  sr7_in = -c6_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         arg1_ff <= arg1_in;
         oct1_ff <= phase[18:16];
         r1_ff   <= in_data.den;
      end
      if (en[2]) begin
         z2_ff   <= z2_in;
         arg2_ff <= arg1_ff;
         oct2_ff <= oct1_ff;
         r2_ff   <= r1_ff;
      end
      if (en[3]) begin
         ps3_ff  <= qmul30(z2_ff, SIN_K3) + SIN_K2;
         pc3_ff  <= qmul30(z2_ff, COS_K3) + COS_K2;
         z3_ff   <= z2_ff;
         arg3_ff <= arg2_ff;
         oct3_ff <= oct2_ff;
         r3_ff   <= r2_ff;
      end
      if (en[4]) begin
         ps4_ff  <= qmul30(z3_ff, ps3_ff) + SIN_K1;
         pc4_ff  <= qmul30(z3_ff, pc3_ff) + COS_K1;
         z4_ff   <= z3_ff;
         arg4_ff <= arg3_ff;
         oct4_ff <= oct3_ff;
         r4_ff   <= r3_ff;
      end
      if (en[5]) begin
         ps5_ff  <= qmul30(z4_ff, ps4_ff) + SIN_K0;
         pc5_ff  <= qmul30(z4_ff, pc4_ff) + COS_K0;
         z5_ff   <= z4_ff;
         arg5_ff <= arg4_ff;
         oct5_ff <= oct4_ff;
         r5_ff   <= r4_ff;
      end
      if (en[6]) begin
         // odd octants reflect about the octant edge: swap sin and cos
         c6_ff   <= oct5_ff[0] ? s_raw : c_raw;
         s6_ff   <= oct5_ff[0] ? c_raw : s_raw;
         oct6_ff <= oct5_ff;
         r6_ff   <= r5_ff;
      end
      if (en[7]) begin
         cr7_ff <= cr7_in;
         sr7_ff <= sr7_in;
         r7_ff  <= r6_ff;
      end
      if (en[8]) begin
         x8_ff <= scale(r7_ff, cr7_ff);
         y8_ff <= scale(r7_ff, sr7_ff);
      end
   end

   assign out_valid = valid_ff[Stages];
   assign out_x     = x8_ff;
   assign out_y     = y8_ff;

endmodule

`default_nettype wire

### bench/cdm_checker.sv
// Checker for the concentric disk map: watches the request and result
// channels, predicts each disk point and compares it. Depends on nothing.
module cdm_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [15:0]        req_u_coord,
   input  logic [15:0]        req_v_coord,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_disk_x,
   input  logic signed [15:0] rsp_disk_y,
   output int                 fail_count,
   output int                 pending,
   output int                 matched
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } disk_point_type;

   disk_point_type expected_points[$];

   localparam longint SIN_C[4] = '{843314857, -86699834, 2674041, -39273};
   localparam longint COS_C[4] = '{-331168970, 17023474, -350031, 3856};

   // signed Q30 product, magnitude rounded half up
   function automatic longint q30_mul(input longint x, input longint y);
      longint m;
      m = (((x < 0) ? -x : x) * ((y < 0) ? -y : y) + (64'sd1 <<< 29)) >>> 30;
      return ((x < 0) != (y < 0)) ? -m : m;
   endfunction

   function automatic longint q16_ratio(input longint num, input longint den);
      longint m;
      if (den == 0) return 0;
      m = ((((num < 0) ? -num : num) * 131072) / ((den < 0) ? -den : den) + 1) >>> 1;
      return ((num < 0) != (den < 0)) ? -m : m;
   endfunction

   function automatic void octant_trig(input longint f, output longint c,
                                       output longint s);
      longint fq, z, p;
      fq = f <<< 14;
      z  = q30_mul(fq, fq);
      p  = SIN_C[3];
      for (int i = 2; i >= 0; i--) p = q30_mul(z, p) + SIN_C[i];
      s  = q30_mul(fq, p);
      p  = COS_C[3];
      for (int i = 2; i >= 0; i--) p = q30_mul(z, p) + COS_C[i];
      c  = q30_mul(z, p) + 64'sd1073741824;
   endfunction

   function automatic logic [15:0] scale_sat(input longint r, input longint t);
      longint m;
      m = (r * ((t < 0) ? -t : t) + (64'sd1 <<< 30)) >>> 31;
      if (t < 0) return (m > 32768) ? 16'h8000 : 16'(-m);
      return (m > 32767) ? 16'h7fff : 16'(m);
   endfunction

   function automatic disk_point_type map_to_disk(input logic [15:0] u, input logic [15:0] v);
      longint a, b, r, ph, c, s, cr, sr;
      logic [18:0] q;
      disk_point_type p;
      a = 2 * longint'(u) - 65536;
      b = 2 * longint'(v) - 65536;
      if (a > -b) begin
         if (a > b) begin
            r = a; ph = q16_ratio(b, a);
         end else begin
            r = b; ph = 2 * 65536 - q16_ratio(a, b);
         end
      end else if (a < b) begin
         r = -a; ph = 4 * 65536 + q16_ratio(b, a);
      end else begin
         r = -b; ph = (b != 0) ? 6 * 65536 - q16_ratio(a, b) : 0;
      end
      q = 19'(ph);
      // odd octants reflect about the octant edge
      if (q[16]) octant_trig(65536 - longint'(q[15:0]), s, c);
      else       octant_trig(longint'(q[15:0]), c, s);
      case (q[18:17])
         2'd0: begin cr = c;  sr = s;  end
         2'd1: begin cr = -s; sr = c;  end
         2'd2: begin cr = -c; sr = -s; end
         default: begin cr = s; sr = -c; end
      endcase
      p.x = scale_sat(r, cr);
      p.y = scale_sat(r, sr);
      return p;
   endfunction

   assign pending = expected_points.size();

   initial begin
      fail_count = 0;
      matched    = 0;
   end

   always @(posedge clock) begin
      disk_point_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_points.push_back(map_to_disk(req_u_coord, req_v_coord));
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected result x=%0d y=%0d", $time, rsp_disk_x, rsp_disk_y);
               fail_count++;
            end else begin
               want = expected_points.pop_front();
               if (want.x !== rsp_disk_x) begin
                  $display("%0t: disk_x expected %0d actual %0d", $time, want.x, rsp_disk_x);
                  fail_count++;
               end
               if (want.y !== rsp_disk_y) begin
                  $display("%0t: disk_y expected %0d actual %0d", $time, want.y, rsp_disk_y);
                  fail_count++;
               end
               if (want.x === rsp_disk_x && want.y === rsp_disk_y) matched++;
            end
         end
      end
   end
endmodule

### bench/tb_concentric_disk_map_core.sv
// Top of the concentric disk map bench: clock, reset, request and result
// stimulus. Depends on concentric_disk_map_core and cdm_checker.
module tb_concentric_disk_map_core;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [15:0]        req_u_coord = 0;
   logic [15:0]        req_v_coord = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [15:0] rsp_disk_x;
   logic signed [15:0] rsp_disk_y;
   int                 fail_count, pending, matched;
   int                 sent = 0;
   int                 burst_left = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   concentric_disk_map_core dut (.*);

   cdm_checker checker_i (.*);

   task automatic send_request(input logic [15:0] u, input logic [15:0] v);
      if (burst_left == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(0, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_valid   <= 1;
      req_u_coord <= u;
      req_v_coord <= v;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      sent++;
   endtask

   task automatic drain_results();
      req_valid <= 0;
      // let the checker record the last accepted request first
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // result side: stall patterns, one long hold-off to back up the pipeline
   initial begin
      int cyc;
      int mode;
      int seg;
      cyc = 0;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 2);
         seg  = $urandom_range(20, 120);
         repeat (seg) begin
            @(posedge clock);
            cyc++;
            if (cyc >= 2000 && cyc < 2300) rsp_ready <= 0;
            else if (mode == 0) rsp_ready <= 1;
            else if (mode == 1) rsp_ready <= $urandom_range(0, 1);
            else rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   initial begin
      logic [15:0] u, v, d;
      logic [15:0] dir_u[$];
      logic [15:0] dir_v[$];
      dir_u = '{0, 65535, 0, 65535, 32768, 32768, 0, 65535, 32768, 40000, 20000,
                60000, 60000, 32769, 32767, 32768, 32768, 5000, 1, 65535, 32768,
                16384, 49152};
      dir_v = '{0, 65535, 65535, 0, 32768, 0, 32768, 32768, 65535, 40000, 45536,
                59999, 60000, 32768, 32768, 32767, 32769, 60536, 65535, 1, 1,
                16384, 16384};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // edges, region boundaries, center, ratio rounding onto an octant edge
      foreach (dir_u[i]) send_request(dir_u[i], dir_v[i]);
      drain_results();
      for (int n = 0; n < 1425; n++) begin
         if (n == 700) drain_results();
         case ($urandom_range(0, 5))
            0: begin
               // near the center
               u = 16'(32768 + $urandom_range(0, 8) - 4);
               v = 16'(32768 + $urandom_range(0, 8) - 4);
            end
            1: begin
               // near a diagonal boundary
               u = 16'($urandom);
               d = 16'($urandom_range(0, 4) - 2);
               v = $urandom_range(0, 1) ? 16'(u + d) : 16'(16'(65536 - u) + d);
            end
            default: begin
               u = 16'($urandom);
               v = 16'($urandom);
            end
         endcase
         send_request(u, v);
      end
      drain_results();
      repeat (40) @(posedge clock);
      $display("Sent %0d points (edges, center, region boundaries, random), %0d matched.",
               sent, matched);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d results outstanding.", pending);
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
